// ===== rtl/bfsp_pkg.sv =====
// shared widths, register map and defaults for the shortest-path block
package bfsp_pkg;

  localparam int DIST_W     = 22;
  localparam int VIDX_W     = 6;
  localparam int WFIELD_W   = 16;
  localparam int VCOUNT_W   = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 1024;
  localparam int DEF_WEIGHT_BITS  = 16;

  // register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_SOURCE_VERTEX = 1'b1;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [VIDX_W-1:0]   SOURCE_RESET = 6'd0;

endpackage

// ===== rtl/bfsp_ram.sv =====
// generic simple dual-port ram with registered read
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bfsp_relax.sv =====
// shared relaxation unit: candidate sum, compare against target and saturation
module bfsp_relax #(
  parameter int WEIGHT_BITS = bfsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                sum_en,
  input  logic signed [bfsp_pkg::DIST_W-1:0]  dist_in,
  input  logic signed [WEIGHT_BITS-1:0]       wt_in,
  output logic                                less,
  output logic signed [bfsp_pkg::DIST_W-1:0]  cand_sat
);
  import bfsp_pkg::*;

  localparam int SUM_W = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

  logic signed [SUM_W-1:0]    cand_r;
  logic signed [SUM_W-1:0]    cand_nxt;
  logic signed [SUM_W-1:0]    dist_ext;
  logic [SUM_W-DIST_W:0]      hi_bits;
  logic                       fits;

  assign dist_ext = SUM_W'(dist_in);
  assign cand_nxt = dist_ext + SUM_W'(wt_in);

  always_ff @(posedge clk) begin
    if (sum_en) begin
      cand_r <= cand_nxt;
    end
  end

  // exact compare, before saturation
  assign less = cand_r < dist_ext;

  assign hi_bits = cand_r[SUM_W-1:DIST_W-1];
  assign fits    = (&hi_bits) | (~|hi_bits);

  always_comb begin
    if (fits) begin
      cand_sat = cand_r[DIST_W-1:0];
    end else if (cand_r[SUM_W-1]) begin
      cand_sat = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      cand_sat = {1'b0, {(DIST_W-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/bellman_ford_shortest_paths.sv =====
// top level: edge loader, relaxation sequencer, result stream and register port
//
// Edges stream in one beat per cycle while the block is idle and are written to
// the edge ram; the beat with tlast set starts a run (an edge beyond MAX_EDGES
// is dropped but its tlast still starts the run). During a run the block is not
// ready. Each pass walks the stored edges in order: an edge that is out of range
// or whose origin is not yet reached takes only the edge read and decode steps,
// any other edge also the target read and write-back steps, because the distance
// ram has one read port and is read for origin and target in turn before the
// shared adder and compare unit decide. Passes repeat up to vertex_count-1 times
// plus a final check pass and stop early after a pass that changes nothing.
// Results follow a beat per vertex as out_tready allows, or a single beat when a
// negative cycle is found; tlast marks the last beat of a run. The edge count is
// cleared after each run. The rams need no clearing after reset. The next run's
// edges may be loaded while the final result beat still waits to be taken.
module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = bfsp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = bfsp_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = bfsp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // edge_origin[5:0], edge_target[11:6], edge_weight[27:12], zero fill
  input  logic [bfsp_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                 in_tlast,   // edge_final
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // vertex_index[5:0], distance[27:6], reachable[28], zero fill
  output logic [bfsp_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tuser,  // negative_cycle
  output logic                                 out_tlast,  // result_last
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [bfsp_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [bfsp_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import bfsp_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = 2 * VIDX_W + WEIGHT_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_EREAD = 4'd2;
  localparam logic [3:0] S_EDGE  = 4'd3;
  localparam logic [3:0] S_DU    = 4'd4;
  localparam logic [3:0] S_DT    = 4'd5;
  localparam logic [3:0] S_ORD   = 4'd6;
  localparam logic [3:0] S_OWR   = 4'd7;
  localparam logic [3:0] S_NEG   = 4'd8;

  // registers
  logic [3:0]              state_r, state_nxt;
  logic [VCOUNT_W-1:0]     vcount_r;
  logic [VIDX_W-1:0]       source_r;
  logic [ECW-1:0]          ecnt_r, ecnt_nxt;
  logic [ECW-1:0]          idx_r, idx_nxt;
  logic [VCOUNT_W-1:0]     pass_r, pass_nxt;
  logic                    improved_r, improved_nxt;
  logic [VW-1:0]           vtx_r, vtx_nxt;
  logic [MAX_VERTICES-1:0] reach_r, reach_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VIDX_W-1:0]       out_idx_r, out_idx_nxt;
  logic [DIST_W-1:0]       out_dist_r, out_dist_nxt;
  logic                    out_reach_r, out_reach_nxt;
  logic                    out_neg_r, out_neg_nxt;
  logic                    out_last_r, out_last_nxt;

  // configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
      source_r <= SOURCE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_VERTEX_COUNT:  vcount_r <= cfg_pwdata[VCOUNT_W-1:0];
        REG_SOURCE_VERTEX: source_r <= cfg_pwdata[VIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_VERTEX_COUNT:  cfg_prdata = CFG_DATA_W'(vcount_r);
      REG_SOURCE_VERTEX: cfg_prdata = CFG_DATA_W'(source_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // effective vertex count
  logic [VCOUNT_W-1:0] n_eff;
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = VCOUNT_W'(1);
    end else if (vcount_r > VCOUNT_W'(MAX_VERTICES)) begin
      n_eff = VCOUNT_W'(MAX_VERTICES);
    end else begin
      n_eff = vcount_r;
    end
  end

  // input beat decode
  logic [31:0]            wt_field_ext;
  logic [WEIGHT_BITS-1:0] wt_in;
  logic                   in_acc;
  logic                   ecnt_room;

  assign wt_field_ext = 32'(in_tdata[2*VIDX_W +: WFIELD_W]);
  assign wt_in        = wt_field_ext[WEIGHT_BITS-1:0];
  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid & in_tready;
  assign ecnt_room    = ecnt_r < ECW'(MAX_EDGES);

  // edge ram
  logic           eram_we;
  logic           eram_re;
  logic [EW-1:0]  eram_q;
  logic [VIDX_W-1:0] e_org, e_tgt;
  logic signed [WEIGHT_BITS-1:0] e_wt;

  assign eram_we = in_acc & ecnt_room;
  assign eram_re = (state_r == S_EREAD) && (idx_r != ecnt_r);

  bfsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk     (clk),
    .wr_en   (eram_we),
    .wr_addr (ecnt_r[EAW-1:0]),
    .wr_data ({wt_in, in_tdata[2*VIDX_W-1:0]}),
    .rd_en   (eram_re),
    .rd_addr (idx_r[EAW-1:0]),
    .rd_data (eram_q)
  );

  assign e_org = eram_q[VIDX_W-1:0];
  assign e_tgt = eram_q[2*VIDX_W-1:VIDX_W];
  assign e_wt  = $signed(eram_q[2*VIDX_W +: WEIGHT_BITS]);

  // distance ram and relaxation unit
  logic              dram_we;
  logic [VW-1:0]     dram_waddr;
  logic [DIST_W-1:0] dram_wdata;
  logic              dram_re;
  logic [VW-1:0]     dram_raddr;
  logic [DIST_W-1:0] dram_q;
  logic              relax_less;
  logic signed [DIST_W-1:0] relax_sat;
  logic              src_ok;
  logic              edge_skip;
  logic              relax_hit;
  logic              apply;
  logic              slot_free;
  logic              vtx_last;

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk     (clk),
    .wr_en   (dram_we),
    .wr_addr (dram_waddr),
    .wr_data (dram_wdata),
    .rd_en   (dram_re),
    .rd_addr (dram_raddr),
    .rd_data (dram_q)
  );

  bfsp_relax #(.WEIGHT_BITS(WEIGHT_BITS)) u_relax (
    .clk      (clk),
    .sum_en   (state_r == S_DU),
    .dist_in  ($signed(dram_q)),
    .wt_in    (e_wt),
    .less     (relax_less),
    .cand_sat (relax_sat)
  );

  assign src_ok    = {1'b0, source_r} < n_eff;
  assign edge_skip = ({1'b0, e_org} >= n_eff) || ({1'b0, e_tgt} >= n_eff) ||
                     !reach_r[e_org[VW-1:0]];
  assign relax_hit = !reach_r[e_tgt[VW-1:0]] || relax_less;
  assign apply     = pass_r != n_eff;
  assign slot_free = !out_valid_r || out_tready;
  assign vtx_last  = VCOUNT_W'(vtx_r) == (n_eff - VCOUNT_W'(1));

  always_comb begin
    dram_we    = 1'b0;
    dram_waddr = e_tgt[VW-1:0];
    dram_wdata = relax_sat;
    dram_re    = 1'b0;
    dram_raddr = e_org[VW-1:0];
    case (state_r)
      S_INIT: begin
        dram_we    = src_ok;
        dram_waddr = source_r[VW-1:0];
        dram_wdata = '0;
      end
      S_EDGE: begin
        dram_re = !edge_skip;
      end
      S_DU: begin
        dram_re    = 1'b1;
        dram_raddr = e_tgt[VW-1:0];
      end
      S_DT: begin
        dram_we = relax_hit & apply;
      end
      S_ORD: begin
        dram_re    = 1'b1;
        dram_raddr = vtx_r;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ecnt_nxt      = ecnt_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    improved_nxt  = improved_r;
    vtx_nxt       = vtx_r;
    reach_nxt     = reach_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;
    out_reach_nxt = out_reach_r;
    out_neg_nxt   = out_neg_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (ecnt_room) begin
            ecnt_nxt = ecnt_r + ECW'(1);
          end
          if (in_tlast) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        reach_nxt = '0;
        if (src_ok) begin
          reach_nxt[source_r[VW-1:0]] = 1'b1;
        end
        pass_nxt     = VCOUNT_W'(1);
        idx_nxt      = '0;
        improved_nxt = 1'b0;
        state_nxt    = S_EREAD;
      end
      S_EREAD: begin
        if (idx_r == ecnt_r) begin
          // end of pass
          if (!improved_r) begin
            ecnt_nxt  = '0;
            vtx_nxt   = '0;
            state_nxt = S_ORD;
          end else if (!apply) begin
            ecnt_nxt  = '0;
            state_nxt = S_NEG;
          end else begin
            pass_nxt     = pass_r + VCOUNT_W'(1);
            idx_nxt      = '0;
            improved_nxt = 1'b0;
          end
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (edge_skip) begin
          idx_nxt   = idx_r + ECW'(1);
          state_nxt = S_EREAD;
        end else begin
          state_nxt = S_DU;
        end
      end
      S_DU: begin
        state_nxt = S_DT;
      end
      S_DT: begin
        if (relax_hit) begin
          improved_nxt = 1'b1;
          if (apply) begin
            reach_nxt[e_tgt[VW-1:0]] = 1'b1;
          end
        end
        idx_nxt   = idx_r + ECW'(1);
        state_nxt = S_EREAD;
      end
      S_ORD: begin
        state_nxt = S_OWR;
      end
      S_OWR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = VIDX_W'(vtx_r);
          out_reach_nxt = reach_r[vtx_r];
          out_dist_nxt  = reach_r[vtx_r] ? dram_q : '0;
          out_neg_nxt   = 1'b0;
          out_last_nxt  = vtx_last;
          if (vtx_last) begin
            state_nxt = S_IDLE;
          end else begin
            vtx_nxt   = vtx_r + VW'(1);
            state_nxt = S_ORD;
          end
        end
      end
      S_NEG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_reach_nxt = 1'b0;
          out_dist_nxt  = '0;
          out_neg_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ecnt_r      <= '0;
      reach_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ecnt_r      <= ecnt_nxt;
      reach_r     <= reach_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pass_r      <= pass_nxt;
    improved_r  <= improved_nxt;
    vtx_r       <= vtx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_dist_r  <= out_dist_nxt;
    out_reach_r <= out_reach_nxt;
    out_neg_r   <= out_neg_nxt;
    out_last_r  <= out_last_nxt;
  end

  // result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_reach_r, out_dist_r, out_idx_r});
  assign out_tuser  = out_neg_r;
  assign out_tlast  = out_last_r;

endmodule
